FILE: sv/nrudl_pkg.sv
// Shared types and constants of the NR-U downlink user data header parser.
package nrudl_pkg;

    localparam int DATA_W      = 8;
    localparam int SN_W        = 24;
    localparam int POS_W       = 11;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    localparam int TDATA_W     = 64;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LEN   = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_SPARE     = 3'd3;
    localparam logic [2:0] ST_TOO_MANY  = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    localparam logic REC_SUMMARY = 1'b0;
    localparam logic REC_BLOCK   = 1'b1;

    localparam logic CFG_PDU_TYPE   = 1'b0;
    localparam logic CFG_MAX_BLOCKS = 1'b1;

    typedef struct packed {
        logic            record_kind;
        logic [2:0]      status;
        logic            rpt_poll;
        logic            assist_polling;
        logic            retx_flag;
        logic            flush_present;
        logic            blocks_present;
        logic [SN_W-1:0] sequence_value;
        logic [SN_W-1:0] discard_sn;
        logic [7:0]      count_or_size;
        logic            run_end;
    } rec_t;

    typedef struct packed {
        logic [1:0] cnt;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

endpackage

FILE: sv/nrudl_parse.sv
// Per-byte header parser: field position tracking, checks and record build.
module nrudl_parse import nrudl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              last_byte,
    input  logic [3:0]        expected_pdu_type,
    input  logic [7:0]        max_discard_blocks,
    output push_t             push
);

    logic [POS_W-1:0] pos_reg, pos_upd;
    logic [1:0]       mod4_reg, mod4_upd;
    logic [SN_W-1:0]  shift_reg, shift_upd;
    logic [5:0]       flags_reg, flags_upd;
    logic [SN_W-1:0]  seq_reg, seq_upd;
    logic [SN_W-1:0]  dsn_reg, dsn_upd;
    logic [7:0]       total_reg, total_upd;
    logic [7:0]       left_reg, left_upd;
    logic [2:0]       err_reg, err_upd;

    logic       flush, at_q, past_q, blk, done;
    logic [1:0] rel;
    logic [2:0] sum_status;
    rec_t       blk_rec, sum_rec;

    always_comb
    begin
        flush     = flags_reg[1];
        at_q      = flush ? (pos_reg == POS_W'(8)) : (pos_reg == POS_W'(5));
        past_q    = flush ? (pos_reg > POS_W'(8)) : (pos_reg > POS_W'(5));
        rel       = pos_reg[1:0] - (flush ? 2'd0 : 2'd1) - 2'd1;
        blk       = 1'b0;
        shift_upd = shift_reg;
        flags_upd = flags_reg;
        seq_upd   = seq_reg;
        dsn_upd   = dsn_reg;
        total_upd = total_reg;
        left_upd  = left_reg;
        err_upd   = err_reg;

        if (err_reg == ST_OK)
        begin
            if (pos_reg == '0)
            begin
                if (data_byte[7:4] != expected_pdu_type)
                    err_upd = ST_BAD_TYPE;
                else if (data_byte[3])
                    err_upd = ST_SPARE;
                else
                    flags_upd = {3'b000, data_byte[2:0]};
            end
            else if (pos_reg == POS_W'(1))
            begin
                if (data_byte[7:2] != 6'd0)
                    err_upd = ST_SPARE;
                else
                begin
                    flags_upd[3] = data_byte[1];
                    flags_upd[4] = data_byte[0];
                end
            end
            else if (pos_reg <= POS_W'(4))
            begin
                shift_upd = {shift_reg[SN_W-9:0], data_byte};
                if (pos_reg == POS_W'(4))
                    seq_upd = shift_upd;
            end
            else if (flush && pos_reg <= POS_W'(7))
            begin
                shift_upd = {shift_reg[SN_W-9:0], data_byte};
                if (pos_reg == POS_W'(7))
                    dsn_upd = shift_upd;
            end
            else if (flags_reg[2])
            begin
                if (at_q)
                begin
                    if (data_byte > max_discard_blocks)
                        err_upd = ST_TOO_MANY;
                    else
                    begin
                        total_upd    = data_byte;
                        left_upd     = data_byte;
                        flags_upd[5] = 1'b1;
                    end
                end
                else if (past_q && left_reg != 8'd0)
                begin
                    if (rel != 2'd3)
                        shift_upd = {shift_reg[SN_W-9:0], data_byte};
                    else
                    begin
                        blk      = 1'b1;
                        left_upd = left_reg - 8'd1;
                    end
                end
            end
        end

        pos_upd  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
        mod4_upd = mod4_reg + 2'd1;

        done = pos_upd >= (flags_upd[1] ? POS_W'(8) : POS_W'(5));
        if (flags_upd[2])
            done = done && flags_upd[5] && (left_upd == 8'd0);

        if (mod4_upd != 2'd2)
            sum_status = ST_BAD_LEN;
        else if (err_upd != ST_OK)
            sum_status = err_upd;
        else
            sum_status = done ? ST_OK : ST_TRUNC;

        blk_rec                     = '0;
        blk_rec.record_kind         = REC_BLOCK;
        blk_rec.sequence_value      = shift_reg;
        blk_rec.count_or_size       = data_byte;
        blk_rec.run_end             = ~last_byte;

        sum_rec.record_kind         = REC_SUMMARY;
        sum_rec.status              = sum_status;
        sum_rec.rpt_poll            = flags_upd[0];
        sum_rec.assist_polling      = flags_upd[3];
        sum_rec.retx_flag           = flags_upd[4];
        sum_rec.flush_present       = flags_upd[1];
        sum_rec.blocks_present      = flags_upd[2];
        sum_rec.sequence_value      = seq_upd;
        sum_rec.discard_sn          = dsn_upd;
        sum_rec.count_or_size       = total_upd;
        sum_rec.run_end             = 1'b1;

        push.rec0 = blk ? blk_rec : sum_rec;
        push.rec1 = sum_rec;
        push.cnt  = in_valid ? ({1'b0, blk} + {1'b0, last_byte}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            mod4_reg  <= '0;
            shift_reg <= '0;
            flags_reg <= '0;
            seq_reg   <= '0;
            dsn_reg   <= '0;
            total_reg <= '0;
            left_reg  <= '0;
            err_reg   <= ST_OK;
        end
        else if (in_valid)
        begin
            if (last_byte)
            begin
                pos_reg   <= '0;
                mod4_reg  <= '0;
                shift_reg <= '0;
                flags_reg <= '0;
                seq_reg   <= '0;
                dsn_reg   <= '0;
                total_reg <= '0;
                left_reg  <= '0;
                err_reg   <= ST_OK;
            end
            else
            begin
                pos_reg   <= pos_upd;
                mod4_reg  <= mod4_upd;
                shift_reg <= shift_upd;
                flags_reg <= flags_upd;
                seq_reg   <= seq_upd;
                dsn_reg   <= dsn_upd;
                total_reg <= total_upd;
                left_reg  <= left_upd;
                err_reg   <= err_upd;
            end
        end
    end

endmodule

FILE: sv/nrudl_ofifo.sv
// Result queue: takes up to two records per cycle, hands out one per word.
module nrudl_ofifo import nrudl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output rec_t  out_rec
);

    rec_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg, rp_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [FIFO_AW-1:0] wp1;
    logic               pop;

    assign wp1       = wp_reg + FIFO_AW'(1);
    assign out_valid = (count_reg != '0);
    assign out_rec   = mem_reg[rp_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign count_next = count_reg + FIFO_CW'(push.cnt) - FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[wp_reg] <= push.rec0;
        if (push.cnt == 2'd2)
            mem_reg[wp1] <= push.rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + FIFO_AW'(push.cnt);
            rp_reg    <= rp_reg + FIFO_AW'(pop);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> (FIFO_CW'(push.cnt) + count_reg <= FIFO_CW'(FIFO_DEPTH)))
        else $error("push without space");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.cnt == 2'd0) |=> (count_reg == $past(count_reg) - FIFO_CW'(1)))
        else $error("count lost track on pop");

endmodule

FILE: sv/nru_dl_user_data_header_parser_unit.sv
// Top level of the NR-U downlink user data header parser.
//
// Input stream: one PDU byte per word on s_tdata, first bit in bit 7, s_tlast
// on the final byte. Output stream: records on m_tdata, m_tuser = record kind
// (0 summary, 1 discard block), m_tlast = last record caused by that byte.
// A discard block record goes out as each 4-byte block completes; a summary
// with status goes out on the last byte (block record first when both occur).
// Consumers drop block records of a PDU whose summary status is not zero.
// Throughput: one byte per cycle while s_tready is high; an accepted byte's
// records are registered into the queue before they reach m_*. Records pass
// through a 4-word queue; s_tready drops while fewer than two slots are free,
// so a stalled m_tready stalls the input once more than two records wait.
// Config: cfg_we/cfg_addr/cfg_wdata, 0 = expected PDU type, 1 = max blocks;
// write only while idle.
// Reset: parser returns to start of PDU, queue empties, type 0, max 255.
module nru_dl_user_data_header_parser_unit import nrudl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [2:0] status, [3] rpt_poll, [4] assist_polling,
    // [5] retx_flag, [6] flush_present, [7] blocks_present,
    // [31:8] sequence_value, [55:32] discard_sn, [63:56] count_or_size
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,   // [0] record_kind
    output logic               m_tlast,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [7:0]         cfg_wdata
);

    logic [3:0] pdu_type_reg;
    logic [7:0] max_blocks_reg;
    push_t      push;
    rec_t       head;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pdu_type_reg   <= 4'd0;
            max_blocks_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PDU_TYPE:   pdu_type_reg   <= cfg_wdata[3:0];
                CFG_MAX_BLOCKS: max_blocks_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    nrudl_parse u_parse (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (accept),
        .data_byte          (s_tdata),
        .last_byte          (s_tlast),
        .expected_pdu_type  (pdu_type_reg),
        .max_discard_blocks (max_blocks_reg),
        .push               (push)
    );

    nrudl_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (head)
    );

    assign m_tdata = {head.count_or_size, head.discard_sn, head.sequence_value,
                      head.blocks_present, head.flush_present,
                      head.retx_flag, head.assist_polling,
                      head.rpt_poll, head.status};
    assign m_tuser = head.record_kind;
    assign m_tlast = head.run_end;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the NR-U downlink user data header parser unit.
module tb_top;
    import nrudl_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_BYTES = 360;
    localparam int SETTLE       = 8;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;
    logic               cfg_we = 1'b0;
    logic               cfg_addr = 1'b0;
    logic [7:0]         cfg_wdata = '0;

    // parser model state
    logic [3:0]       pdu_type_cfg;
    logic [7:0]       max_blocks_cfg;
    logic [POS_W-1:0] byte_pos;
    logic [1:0]       len_mod;
    logic [SN_W-1:0]  sn_shift;
    logic [5:0]       hdr_flags;
    logic [SN_W-1:0]  seq_latched;
    logic [SN_W-1:0]  dsn_latched;
    logic [7:0]       blk_total;
    logic [7:0]       blk_left;
    logic [2:0]       first_err;

    rec_t       exp_records[$];
    logic [7:0] pdu_bytes[$];
    rec_t       got_rec;
    rec_t       want_rec;

    bit steady = 1'b0;
    int errors = 0;
    int cycles = 0;
    int bytes_sent = 0;
    int pdus_sent = 0;
    int summaries_seen = 0;
    int blocks_seen = 0;
    int cfg_writes = 0;

    nru_dl_user_data_header_parser_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d records outstanding",
                     cycles, exp_records.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic rec_t make_record(input logic kind, input logic [2:0] st,
                                         input logic [5:0] flags,
                                         input logic [SN_W-1:0] seq,
                                         input logic [SN_W-1:0] dsn,
                                         input logic [7:0] cnt, input logic run_end);
        rec_t r;
        r.record_kind         = kind;
        r.status              = st;
        r.rpt_poll            = flags[0];
        r.assist_polling      = flags[3];
        r.retx_flag           = flags[4];
        r.flush_present       = flags[1];
        r.blocks_present      = flags[2];
        r.sequence_value      = seq;
        r.discard_sn          = dsn;
        r.count_or_size       = cnt;
        r.run_end             = run_end;
        return r;
    endfunction

    function automatic void clear_parser();
        byte_pos    = '0;
        len_mod     = '0;
        sn_shift    = '0;
        hdr_flags   = '0;
        seq_latched = '0;
        dsn_latched = '0;
        blk_total   = '0;
        blk_left    = '0;
        first_err   = ST_OK;
    endfunction

    function automatic void expect_record(input rec_t r);
        exp_records = {exp_records, r};
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        pdu_bytes = {pdu_bytes, b};
    endfunction

    // expected records caused by one accepted byte
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        logic [POS_W-1:0] p;
        int unsigned      q;
        int unsigned      rel;
        logic [2:0]       st;
        logic             done;
        p = byte_pos;
        q = hdr_flags[1] ? 8 : 5;
        if (first_err == ST_OK)
        begin
            if (p == 0)
            begin
                if (b[7:4] != pdu_type_cfg)
                    first_err = ST_BAD_TYPE;
                else if (b[3])
                    first_err = ST_SPARE;
                else
                    hdr_flags = {3'b000, b[2:0]};
            end
            else if (p == 1)
            begin
                if (b[7:2] != 6'd0)
                    first_err = ST_SPARE;
                else
                begin
                    hdr_flags[3] = b[1];
                    hdr_flags[4] = b[0];
                end
            end
            else if (p <= 4)
            begin
                sn_shift = {sn_shift[15:0], b};
                if (p == 4)
                    seq_latched = sn_shift;
            end
            else if (hdr_flags[1] && p <= 7)
            begin
                sn_shift = {sn_shift[15:0], b};
                if (p == 7)
                    dsn_latched = sn_shift;
            end
            else if (hdr_flags[2])
            begin
                if (p == q)
                begin
                    if (b > max_blocks_cfg)
                        first_err = ST_TOO_MANY;
                    else
                    begin
                        blk_total    = b;
                        blk_left     = b;
                        hdr_flags[5] = 1'b1;
                    end
                end
                else if (p > q && blk_left > 0)
                begin
                    rel = (p - q - 1) % 4;
                    if (rel < 3)
                        sn_shift = {sn_shift[15:0], b};
                    else
                    begin
                        expect_record(make_record(REC_BLOCK, ST_OK, 6'd0,
                                                  sn_shift, '0, b, !last));
                        blk_left = blk_left - 8'd1;
                    end
                end
            end
        end
        if (byte_pos != POS_MAX)
            byte_pos = byte_pos + POS_W'(1);
        len_mod = len_mod + 2'd1;
        if (last)
        begin
            if (len_mod != 2'd2)
                st = ST_BAD_LEN;
            else if (first_err != ST_OK)
                st = first_err;
            else
            begin
                done = byte_pos >= (hdr_flags[1] ? 8 : 5);
                if (hdr_flags[2])
                    done = done && hdr_flags[5] && blk_left == 0;
                st = done ? ST_OK : ST_TRUNC;
            end
            expect_record(make_record(REC_SUMMARY, st, hdr_flags, seq_latched,
                                      dsn_latched, blk_total, 1'b1));
            clear_parser();
        end
    endfunction

    function automatic string rec_text(input rec_t r);
        return $sformatf("kind=%0d st=%0d rp/ap/rt/fp/bp=%b%b%b%b%b seq=%h dsn=%h cnt=%0d end=%0d",
                         r.record_kind, r.status, r.rpt_poll, r.assist_polling,
                         r.retx_flag, r.flush_present, r.blocks_present,
                         r.sequence_value, r.discard_sn, r.count_or_size, r.run_end);
    endfunction

    function automatic bit same_record(input rec_t a, input rec_t b);
        return a.record_kind === b.record_kind && a.status === b.status &&
               a.rpt_poll === b.rpt_poll &&
               a.assist_polling === b.assist_polling &&
               a.retx_flag === b.retx_flag &&
               a.flush_present === b.flush_present &&
               a.blocks_present === b.blocks_present &&
               a.sequence_value === b.sequence_value &&
               a.discard_sn === b.discard_sn &&
               a.count_or_size === b.count_or_size && a.run_end === b.run_end;
    endfunction

    // record checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_rec.record_kind         = m_tuser;
            got_rec.status              = m_tdata[2:0];
            got_rec.rpt_poll            = m_tdata[3];
            got_rec.assist_polling      = m_tdata[4];
            got_rec.retx_flag           = m_tdata[5];
            got_rec.flush_present       = m_tdata[6];
            got_rec.blocks_present      = m_tdata[7];
            got_rec.sequence_value      = m_tdata[31:8];
            got_rec.discard_sn          = m_tdata[55:32];
            got_rec.count_or_size       = m_tdata[63:56];
            got_rec.run_end             = m_tlast;
            if (got_rec.record_kind == REC_BLOCK)
                blocks_seen++;
            else
                summaries_seen++;
            if (exp_records.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR @%0t unexpected record: %s", $realtime, rec_text(got_rec));
            end
            else
            begin
                want_rec = exp_records.pop_front();
                if (!same_record(want_rec, got_rec))
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("ERROR @%0t record mismatch", $realtime);
                        $display("  expected: %s", rec_text(want_rec));
                        $display("  actual:   %s", rec_text(got_rec));
                    end
                end
            end
        end
    end

    // sink side: random stall before each word, none while steady
    initial
    begin
        int stall;
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_pdu();
        for (int i = 0; i < pdu_bytes.size(); i++)
            send_byte(pdu_bytes[i], i == pdu_bytes.size() - 1);
        pdus_sent++;
    endtask

    task automatic drain_records();
        s_tvalid <= 1'b0;
        while (exp_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic addr, input logic [7:0] value);
        drain_records();
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        if (addr == CFG_PDU_TYPE)
            pdu_type_cfg = value[3:0];
        else
            max_blocks_cfg = value;
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // header, SN, optional discard SN, optional block list, padding to 4n-2
    task automatic build_pdu(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [SN_W-1:0] seq, input logic [SN_W-1:0] dsn,
                             input logic [7:0] cnt, input int nblk);
        pdu_bytes.delete();
        add_byte(b0);
        add_byte(b1);
        add_byte(seq[23:16]);
        add_byte(seq[15:8]);
        add_byte(seq[7:0]);
        if (b0[1])
        begin
            add_byte(dsn[23:16]);
            add_byte(dsn[15:8]);
            add_byte(dsn[7:0]);
        end
        if (b0[2])
        begin
            add_byte(cnt);
            repeat (nblk * 4) add_byte(8'($urandom_range(0, 255)));
        end
        while (pdu_bytes.size() % 4 != 2)
            add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_header_fields();
        build_pdu(8'h00, 8'h00, 24'h000000, 24'h0, 8'd0, 0);
        send_pdu();
        build_pdu(8'h07, 8'h03, 24'hFFFFFF, 24'hFFFFFF, 8'd1, 1);
        send_pdu();
        build_pdu(8'h01, 8'h02, 24'h123456, 24'h0, 8'd0, 0);
        send_pdu();
        // wrong type, spare bits in either header octet
        build_pdu(8'hF0, 8'h00, 24'hABCDEF, 24'h0, 8'd0, 0);
        send_pdu();
        build_pdu(8'h08, 8'h00, 24'h111111, 24'h0, 8'd0, 0);
        send_pdu();
        build_pdu(8'h03, 8'hFC, 24'h222222, 24'h0, 8'd0, 0);
        send_pdu();
        build_pdu(8'h00, 8'h04, 24'h333333, 24'h0, 8'd0, 0);
        send_pdu();
        // bad length outranks a wrong type
        build_pdu(8'h50, 8'h00, 24'h444444, 24'h0, 8'd0, 0);
        pdu_bytes.pop_back();
        send_pdu();
        pdu_bytes = '{8'hFF};
        send_pdu();
        // two-byte and six-byte PDUs cut short of their fields
        pdu_bytes = '{8'h01, 8'h01};
        send_pdu();
        pdu_bytes = '{8'h02, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78};
        send_pdu();
        pdu_bytes = '{8'h06, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78};
        send_pdu();
    endtask

    task automatic test_discard_blocks();
        // count of zero, count read as the last byte
        build_pdu(8'h04, 8'h00, 24'h0A0B0C, 24'h0, 8'd0, 0);
        send_pdu();
        // without flush the last block ends on the last byte
        build_pdu(8'h05, 8'h01, 24'hFEDCBA, 24'h0, 8'd3, 3);
        send_pdu();
        build_pdu(8'h06, 8'h02, 24'h000001, 24'h800000, 8'd2, 2);
        send_pdu();
        // block list cut short
        build_pdu(8'h04, 8'h00, 24'h000002, 24'h0, 8'd3, 2);
        send_pdu();
        write_cfg(CFG_MAX_BLOCKS, 8'd0);
        build_pdu(8'h04, 8'h00, 24'h000003, 24'h0, 8'd0, 0);
        send_pdu();
        build_pdu(8'h06, 8'h00, 24'h000004, 24'h123456, 8'd1, 1);
        send_pdu();
        write_cfg(CFG_MAX_BLOCKS, 8'd2);
        build_pdu(8'h04, 8'h00, 24'h000005, 24'h0, 8'd2, 2);
        send_pdu();
        build_pdu(8'h04, 8'h00, 24'h000006, 24'h0, 8'd3, 3);
        send_pdu();
        // count at the limit of 255 is accepted, list ends early
        write_cfg(CFG_MAX_BLOCKS, 8'd255);
        build_pdu(8'h07, 8'h03, 24'hFFFFFF, 24'hFFFFFF, 8'd255, 3);
        send_pdu();
    endtask

    task automatic test_type_codes();
        write_cfg(CFG_PDU_TYPE, 8'd15);
        build_pdu(8'hF7, 8'h03, 24'h765432, 24'h0ABCDE, 8'd1, 1);
        send_pdu();
        build_pdu(8'h07, 8'h00, 24'h765432, 24'h0ABCDE, 8'd1, 1);
        send_pdu();
        write_cfg(CFG_PDU_TYPE, 8'd0);
    endtask

    task automatic test_long_pdu();
        // padding after the parsed fields is ignored
        steady = 1'b1;
        build_pdu(8'h03, 8'h00, 24'h5A5A5A, 24'hA5A5A5, 8'd0, 0);
        while (pdu_bytes.size() < 202)
            add_byte(8'($urandom_range(0, 255)));
        send_pdu();
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int         sent0;
        int         mode;
        int         nblk;
        int         cnt;
        int         cut;
        logic [3:0] ty;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [31:0] rnd;
        sent0 = bytes_sent;
        while (bytes_sent - sent0 < RANDOM_BYTES)
        begin
            mode = $urandom_range(0, 2);
            write_cfg(CFG_PDU_TYPE, mode == 0 ? 8'd0 : mode == 1 ? 8'd15
                                    : 8'($urandom_range(0, 15)));
            mode = $urandom_range(0, 3);
            write_cfg(CFG_MAX_BLOCKS, mode == 0 ? 8'd0 : mode == 1 ? 8'd255
                                      : mode == 2 ? 8'($urandom_range(1, 6))
                                      : 8'($urandom_range(0, 255)));
            steady = $urandom_range(0, 3) == 0;
            repeat ($urandom_range(8, 20))
            begin
                rnd = $urandom;
                ty  = $urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 15)) : pdu_type_cfg;
                b0  = {ty, $urandom_range(0, 19) == 0, rnd[2:0]};
                b1  = $urandom_range(0, 19) == 0 ? rnd[15:8] : {6'd0, rnd[5:4]};
                nblk = $urandom_range(0, max_blocks_cfg < 4 ? max_blocks_cfg : 4);
                cnt  = nblk;
                if ($urandom_range(0, 19) == 0)
                begin
                    cnt  = $urandom_range(0, 255);
                    nblk = cnt < 6 ? cnt : 6;
                end
                build_pdu(b0, b1, 24'($urandom), 24'($urandom), 8'(cnt), nblk);
                mode = $urandom_range(0, 99);
                if (mode < 6)
                begin
                    cut = $urandom_range(1, pdu_bytes.size() - 1);
                    repeat (cut) pdu_bytes.pop_back();
                end
                else if (mode < 12 && pdu_bytes.size() > 6)
                    repeat (4) pdu_bytes.pop_back();
                else if (mode < 16)
                    add_byte(8'($urandom_range(0, 255)));
                send_pdu();
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        pdu_type_cfg   = 4'd0;
        max_blocks_cfg = 8'd255;
        clear_parser();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_fields();
        test_discard_blocks();
        test_type_codes();
        test_long_pdu();
        test_random_traffic();

        drain_records();
        $display("Sent %0d PDUs in %0d bytes; checked %0d summary and %0d block records",
                 pdus_sent, bytes_sent, summaries_seen, blocks_seen);
        $display("Made %0d register writes, type codes 0..15 and block limits 0..255",
                 cfg_writes);
        if (errors == 0 && exp_records.size() == 0)
            $display("Testbench completed without errors");
        else
        begin
            $display("%0d mismatches, %0d records never seen", errors, exp_records.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/nrudl_pkg.sv
sv/nrudl_parse.sv
sv/nrudl_ofifo.sv
sv/nru_dl_user_data_header_parser_unit.sv
verif/tb_top.sv
